// ===== design/sqrot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sqrot_pkg;

  localparam int PIX_W      = 8;
  localparam int SIDE_CFG_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  REG_SIDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_TURNS = 1'b1;

  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 4'd8;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic row_end;
    logic image_end;
  } mark_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    mark_t            mark;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/sqrot_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqrot_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [sqrot_pkg::PIX_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [sqrot_pkg::PIX_W-1:0] rd_data
);
  import sqrot_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/sqrot_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqrot_outq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire sqrot_pkg::mark_t            rd_mark,
  input  wire logic [sqrot_pkg::PIX_W-1:0] rd_data,
  output logic                             space,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [sqrot_pkg::PIX_W-1:0] out_pixel_out,
  output logic                             out_row_end,
  output logic                             out_image_end
);
  import sqrot_pkg::*;

  logic       pend_r;
  mark_t      pend_mark_r;
  logic [1:0] cnt_r, cnt_nxt;
  entry_t     head_r, head_nxt;
  entry_t     tail_r, tail_nxt;

  logic       pop;
  logic [1:0] occ_after;
  logic [1:0] cnt_after_pop;
  entry_t     fresh;

  assign out_valid     = (cnt_r != 2'd0);
  assign pop           = out_valid && !out_stall;
  assign occ_after     = cnt_r + {1'b0, pend_r} - {1'b0, pop};
  assign space         = (occ_after < 2'd2);
  assign cnt_after_pop = cnt_r - {1'b0, pop};
  assign fresh         = '{pixel: rd_data, mark: pend_mark_r};

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop && (cnt_r == 2'd2)) begin
      head_nxt = tail_r;
    end
    if (pend_r) begin
      if (cnt_after_pop == 2'd0) begin
        head_nxt = fresh;
      end else begin
        tail_nxt = fresh;
      end
    end
    cnt_nxt = cnt_after_pop + {1'b0, pend_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= rd_en;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_mark_r <= rd_mark;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
  end

  assign out_pixel_out = head_r.pixel;
  assign out_row_end   = head_r.mark.row_end;
  assign out_image_end = head_r.mark.image_end;

endmodule

`default_nettype wire

// ===== design/sqrot_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqrot_ctrl #(
  parameter int MAX_SIDE = 8,
  parameter int AW       = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [sqrot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sqrot_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  output logic                                  wr_en,
  output logic      [AW-1:0]                    wr_addr,
  input  wire logic                             space,
  output logic                                  rd_en,
  output logic      [AW-1:0]                    rd_addr,
  output sqrot_pkg::mark_t                      rd_mark
);
  import sqrot_pkg::*;

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CW     = $clog2(MAX_SIDE * MAX_SIDE + 1);

  state_t                state_r, state_nxt;
  logic [SIDE_CFG_W-1:0] side_cfg_r, side_cfg_nxt;
  logic [1:0]            turns_cfg_r, turns_cfg_nxt;
  logic [1:0]            turns_r, turns_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      row_r, row_nxt;
  logic [IDX_W-1:0]      col_r, col_nxt;

  logic [SIDE_W-1:0]     n_eff;
  logic [IDX_W-1:0]      nm1;
  logic [CW-1:0]         total;
  logic [CW-1:0]         cnt_inc;
  logic [IDX_W-1:0]      src_row, src_col;
  logic                  accept;
  logic                  last_col, last_row;

  always_comb begin
    if (side_cfg_r == '0) begin
      n_eff = SIDE_W'(1);
    end else if (side_cfg_r > SIDE_CFG_W'(MAX_SIDE)) begin
      n_eff = SIDE_W'(MAX_SIDE);
    end else begin
      n_eff = SIDE_W'(side_cfg_r);
    end
  end

  assign nm1      = IDX_W'(n_eff - SIDE_W'(1));
  assign total    = CW'(n_eff) * CW'(n_eff);
  assign cnt_inc  = cnt_r + CW'(1);
  assign last_col = (col_r == nm1);
  assign last_row = (row_r == nm1);

  always_comb begin
    case (turns_r)
      ROT_90: begin
        src_row = nm1 - col_r;
        src_col = row_r;
      end
      ROT_180: begin
        src_row = nm1 - row_r;
        src_col = nm1 - col_r;
      end
      ROT_270: begin
        src_row = col_r;
        src_col = nm1 - row_r;
      end
      default: begin
        src_row = row_r;
        src_col = col_r;
      end
    endcase
  end

  assign rd_addr           = AW'(AW'(src_row) * AW'(n_eff) + AW'(src_col));
  assign rd_mark.row_end   = last_col;
  assign rd_mark.image_end = last_col && last_row;
  assign wr_addr           = cnt_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    side_cfg_nxt  = side_cfg_r;
    turns_cfg_nxt = turns_cfg_r;
    turns_nxt     = turns_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    in_stall      = 1'b0;
    accept        = 1'b0;
    rd_en         = 1'b0;

    case (state_r)
      ST_LOAD: begin
        accept = in_valid;
        if (accept) begin
          if (cnt_inc >= total) begin
            cnt_nxt   = '0;
            turns_nxt = turns_cfg_r;
            row_nxt   = '0;
            col_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ST_EMIT: begin
        in_stall = 1'b1;
        rd_en    = space;
        if (space) begin
          if (last_col) begin
            col_nxt = '0;
            row_nxt = row_r + IDX_W'(1);
            if (last_row) begin
              state_nxt = ST_LOAD;
            end
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_SIDE: begin
          side_cfg_nxt = cfg_data[SIDE_CFG_W-1:0];
          cnt_nxt      = '0;
        end
        REG_TURNS: begin
          turns_cfg_nxt = cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_en = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      side_cfg_r  <= SIDE_RESET;
      turns_cfg_r <= ROT_0;
      turns_r     <= ROT_0;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      side_cfg_r  <= side_cfg_nxt;
      turns_cfg_r <= turns_cfg_nxt;
      turns_r     <= turns_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/square_image_quarter_turn_rotator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// in       in_valid / in_stall  in_pixel_in
// out      out_valid/ out_stall out_pixel_out, out_row_end, out_image_end
// cfg      cfg_we               cfg_index, cfg_data
//
// Loading writes each accepted pixel into the pixel memory at the load count.
// The transaction that completes an N x N image starts readout: one memory read per
// cycle while the two-entry output queue has room, each read pixel passing through
// the memory read register into the queue. Input stalls during readout.
// Reset clears control state only; the pixel memory is never cleared.

module square_image_quarter_turn_rotator_top #(
  parameter int MAX_SIDE = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [sqrot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sqrot_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sqrot_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [sqrot_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                                  out_row_end,
  output logic                                  out_image_end
);
  import sqrot_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  mark_t            rd_mark;
  logic [PIX_W-1:0] rd_data;
  logic             space;

  sqrot_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .space     (space),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_mark   (rd_mark)
  );

  sqrot_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_pixel_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sqrot_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_en         (rd_en),
    .rd_mark       (rd_mark),
    .rd_data       (rd_data),
    .space         (space),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end)
  );

endmodule

`default_nettype wire
